// ===== src/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define WGES_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked property that also holds during reset
`define WGES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/wges_pkg.sv =====
package wges_pkg;

	// default graph size
	localparam int NUM_VERTICES_DEF = 8;

	// field widths
	localparam int VERTEX_W = 4;
	localparam int WEIGHT_W = 16;

	// packed stream widths
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;

	// request kinds carried in tuser
	localparam logic REQ_QUERY  = 1'b0;
	localparam logic REQ_MODIFY = 1'b1;

endpackage

// ===== src/weighted_graph_edge_store.sv =====
// weighted_graph_edge_store
// Undirected weighted graph over vertices 1..NUM_VERTICES, kept as a symmetric
// weight matrix in one synchronous memory plus a per-entry edge-present bitmap.
// Input stream s_*: tuser selects query (0) or modify (1); tdata holds vertex_a,
// vertex_b and weight. Output stream m_*: one transaction per neighbour of a
// queried vertex in ascending order, tlast on the final one; tuser flags an
// error transaction (tdata zero, tlast high).
// Sequence: a query is accepted, and then each neighbour takes a memory read
// (ST_SCAN) followed by the load of the output register (ST_FILL). A modify
// that sets an edge makes two writes on the single write port, the second in
// ST_WR2. A removal or an error is done at acceptance, and an error result
// shows in the next cycle.
// Reset clears the edge-present bitmap at once, so the graph is empty and no
// clearing pass over the memory is needed; the output register is emptied.
// When the receiver stalls, the result holds in the output register, the scan
// waits, and no new input transaction is taken until the register is free.
module weighted_graph_edge_store
	import wges_pkg::*;
#(
	parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // vertex_a[3:0], vertex_b[7:4], weight[23:8]
	input  logic                 s_tuser,  // req_type
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // neighbour[3:0], edge_weight[19:4], zero pad
	output logic                 m_tuser,  // error
	output logic                 m_tlast
);

	localparam int IDX_W  = $clog2(NUM_VERTICES);
	localparam int DEPTH  = NUM_VERTICES * NUM_VERTICES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PAD_W  = M_TDATA_W - VERTEX_W - WEIGHT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_WR2  = 2'd3;

	logic [1:0]              state_q;
	logic [NUM_VERTICES-1:0] pres_q [NUM_VERTICES];
	logic [WEIGHT_W-1:0]     mem [DEPTH];

	logic [IDX_W-1:0]        row_q;
	logic [NUM_VERTICES-1:0] rem_q;
	logic [ADDR_W-1:0]       wb_addr_q;
	logic [WEIGHT_W-1:0]     wt_q;
	logic [IDX_W-1:0]        col_s1;
	logic                    last_s1;
	logic [WEIGHT_W-1:0]     rd_s1;

	logic                    out_valid_q;
	logic                    out_err_q;
	logic [VERTEX_W-1:0]     out_nb_q;
	logic [WEIGHT_W-1:0]     out_w_q;
	logic                    out_last_q;

	// input fields
	logic                    req;
	logic [VERTEX_W-1:0]     va, vb, va_m1, vb_m1;
	logic [WEIGHT_W-1:0]     wt;
	logic [IDX_W-1:0]        ri, ci;
	logic                    va_ok, vb_ok;
	logic [NUM_VERTICES-1:0] row_bits;
	logic                    edge_here;

	assign req   = s_tuser;
	assign va    = s_tdata[VERTEX_W-1:0];
	assign vb    = s_tdata[2*VERTEX_W-1:VERTEX_W];
	assign wt    = s_tdata[2*VERTEX_W+WEIGHT_W-1:2*VERTEX_W];
	assign va_m1 = va - VERTEX_W'(1);
	assign vb_m1 = vb - VERTEX_W'(1);
	assign ri    = va_m1[IDX_W-1:0];
	assign ci    = vb_m1[IDX_W-1:0];
	assign va_ok = (va != '0) && (va <= VERTEX_W'(NUM_VERTICES));
	assign vb_ok = (vb != '0) && (vb <= VERTEX_W'(NUM_VERTICES));

	// row bitmap and edge lookup, gated by range checks
	always_comb begin
		row_bits  = '0;
		edge_here = 1'b0;
		if (va_ok) begin
			row_bits = pres_q[ri];
			if (vb_ok) begin
				edge_here = row_bits[ci];
			end
		end
	end

	// handshake
	logic out_free, acc;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;

	// lowest pending neighbour of the scanned row
	logic [IDX_W-1:0]        low_idx;
	logic [NUM_VERTICES-1:0] rem_next;
	always_comb begin
		low_idx = '0;
		for (int i = NUM_VERTICES - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				low_idx = IDX_W'(i);
			end
		end
	end
	assign rem_next = rem_q & (rem_q - NUM_VERTICES'(1));

	// memory port control
	logic                mem_we, mem_re;
	logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
	logic [WEIGHT_W-1:0] mem_wdata;
	logic                do_set;

	assign do_set = acc && (req == REQ_MODIFY) && va_ok && vb_ok && (wt != '0);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'(ADDR_W'(ri) * ADDR_W'(NUM_VERTICES) + ADDR_W'(ci));
		mem_wdata = wt;
		if (do_set) begin
			mem_we = 1'b1;
		end else if (state_q == ST_WR2) begin
			mem_we    = 1'b1;
			mem_waddr = wb_addr_q;
			mem_wdata = wt_q;
		end
	end

	assign mem_re    = (state_q == ST_SCAN) && out_free;
	assign mem_raddr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(NUM_VERTICES) + ADDR_W'(low_idx));

	// weight memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_s1 <= mem[mem_raddr];
		end
	end

	// scan and write-back payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			row_q     <= ri;
			rem_q     <= row_bits;
			wt_q      <= wt;
			wb_addr_q <= ADDR_W'(ADDR_W'(ci) * ADDR_W'(NUM_VERTICES) + ADDR_W'(ri));
		end else if (mem_re) begin
			rem_q <= rem_next;
		end
		if (mem_re) begin
			col_s1  <= low_idx;
			last_s1 <= (rem_next == '0);
		end
	end

	// sequencer, edge-present bitmap and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int r = 0; r < NUM_VERTICES; r++) begin
				pres_q[r] <= '0;
			end
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (req == REQ_QUERY) begin
							if (row_bits == '0) begin
								out_valid_q <= 1'b1;
							end else begin
								state_q <= ST_SCAN;
							end
						end else if (!va_ok || !vb_ok) begin
							out_valid_q <= 1'b1;
						end else if (wt == '0) begin
							if (!edge_here) begin
								out_valid_q <= 1'b1;
							end else begin
								pres_q[ri][ci] <= 1'b0;
								pres_q[ci][ri] <= 1'b0;
							end
						end else begin
							pres_q[ri][ci] <= 1'b1;
							pres_q[ci][ri] <= 1'b1;
							state_q        <= ST_WR2;
						end
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					out_valid_q <= 1'b1;
					state_q     <= last_s1 ? ST_IDLE : ST_SCAN;
				end
				ST_WR2: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output payload: error result at acceptance, neighbour result after a read
	always_ff @(posedge clk) begin
		if (acc) begin
			out_err_q  <= 1'b1;
			out_nb_q   <= '0;
			out_w_q    <= '0;
			out_last_q <= 1'b1;
		end else if (state_q == ST_FILL) begin
			out_err_q  <= 1'b0;
			out_nb_q   <= VERTEX_W'(col_s1) + VERTEX_W'(1);
			out_w_q    <= rd_s1;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_w_q, out_nb_q};
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== src/wges_checker.sv =====
`include "assert_macros.svh"

// port-level checks of the edge store
module wges_checker
	import wges_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,  // vertex_a[3:0], vertex_b[7:4], weight[23:8]
	input logic                 s_tuser,  // req_type
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,  // neighbour[3:0], edge_weight[19:4], zero pad
	input logic                 m_tuser,  // error
	input logic                 m_tlast
);

	// stalled result holds
	`WGES_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	// error transaction is a single zero result closing the request
	`WGES_ASSERT(a_err_form, clk, arst_n, m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0), "malformed error result")

	// a neighbour result names a real vertex
	`WGES_ASSERT(a_nb_nonzero, clk, arst_n, m_tvalid && !m_tuser |-> (m_tdata[VERTEX_W-1:0] != '0), "neighbour zero")

	// no input taken while a result is stalled
	`WGES_ASSERT(a_no_accept_stall, clk, arst_n, m_tvalid && !m_tready |-> !s_tready, "input taken during stall")

	// nothing offered during reset
	`WGES_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind weighted_graph_edge_store wges_checker u_wges_checker (.*);

// ===== tb/sv/weighted_graph_edge_store_checker.sv =====
`timescale 1ns / 1ps

module weighted_graph_edge_store_checker
	import wges_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // vertex_a[3:0], vertex_b[7:4], weight[23:8]
	input  logic                 s_tuser,  // req_type
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,  // neighbour[3:0], edge_weight[19:4], zero pad
	input  logic                 m_tuser,  // error
	input  logic                 m_tlast,
	output int                   mismatches,
	output int                   pending,
	output int                   results_seen,
	output int                   errors_seen
);

	localparam int NV = NUM_VERTICES_DEF;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic                error;
		logic [VERTEX_W-1:0] neighbour;
		logic [WEIGHT_W-1:0] edge_weight;
		logic                last;
	} graph_result_t;

	// results still owed by the block, oldest first
	graph_result_t expected_results[$];

	// shadow copy of the symmetric weight matrix
	logic [WEIGHT_W-1:0] shadow_weights [1:NV][1:NV];

	function automatic bit vertex_in_range(input logic [VERTEX_W-1:0] v);
		return (v >= 1) && (v <= NV);
	endfunction

	function automatic void push_error_result();
		graph_result_t r;
		r.error       = 1'b1;
		r.neighbour   = '0;
		r.edge_weight = '0;
		r.last        = 1'b1;
		expected_results.push_back(r);
	endfunction

	// apply one request to the shadow graph and queue what it should produce
	function automatic void predict_graph_request(input logic req_kind,
			input logic [VERTEX_W-1:0] va, input logic [VERTEX_W-1:0] vb,
			input logic [WEIGHT_W-1:0] w);
		graph_result_t hits[$];
		graph_result_t r;
		if (req_kind == REQ_QUERY) begin
			if (!vertex_in_range(va)) begin
				push_error_result();
				return;
			end
			for (int j = 1; j <= NV; j++) begin
				if (shadow_weights[va][j] != '0) begin
					r.error       = 1'b0;
					r.neighbour   = VERTEX_W'(j);
					r.edge_weight = shadow_weights[va][j];
					r.last        = 1'b0;
					hits.push_back(r);
				end
			end
			if (hits.size() == 0) begin
				push_error_result();
				return;
			end
			for (int k = 0; k < hits.size(); k++) begin
				r = hits[k];
				r.last = (k == hits.size() - 1);
				expected_results.push_back(r);
			end
		end else begin
			if (!vertex_in_range(va) || !vertex_in_range(vb)) begin
				push_error_result();
			end else if (w == '0) begin
				// removing an edge that is not there is an error
				if (shadow_weights[va][vb] == '0) begin
					push_error_result();
				end else begin
					shadow_weights[va][vb] = '0;
					shadow_weights[vb][va] = '0;
				end
			end else begin
				shadow_weights[va][vb] = w;
				shadow_weights[vb][va] = w;
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (mismatches < MAX_PRINTED)
			$display("MISMATCH at %0t ns: %s expected 0x%0h got 0x%0h", $time, what,
				exp_v, got_v);
		mismatches++;
	endtask

	// compare output transactions first, then predict from the input transaction
	always @(posedge clk or negedge arst_n) begin
		graph_result_t exp_r;
		if (!arst_n) begin
			expected_results.delete();
			for (int a = 1; a <= NV; a++)
				for (int b = 1; b <= NV; b++)
					shadow_weights[a][b] = '0;
			mismatches   = 0;
			results_seen = 0;
			errors_seen  = 0;
			pending      = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tuser)
					errors_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing pending, tdata", '0, m_tdata);
				end else begin
					exp_r = expected_results.pop_front();
					if (m_tuser !== exp_r.error)
						report_mismatch("error flag", exp_r.error, m_tuser);
					if (m_tdata[3:0] !== exp_r.neighbour)
						report_mismatch("neighbour", exp_r.neighbour, m_tdata[3:0]);
					if (m_tdata[19:4] !== exp_r.edge_weight)
						report_mismatch("edge weight", exp_r.edge_weight, m_tdata[19:4]);
					if (m_tlast !== exp_r.last)
						report_mismatch("last flag", exp_r.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready)
				predict_graph_request(s_tuser, s_tdata[3:0], s_tdata[7:4], s_tdata[23:8]);
			pending = expected_results.size();
		end
	end

endmodule

// ===== tb/sv/weighted_graph_edge_store_tb.sv =====
`timescale 1ns / 1ps

module weighted_graph_edge_store_tb;
	import wges_pkg::*;

	localparam int NV           = NUM_VERTICES_DEF;
	localparam int RANDOM_ITEMS = 450;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 20;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;  // vertex_a[3:0], vertex_b[7:4], weight[23:8]
	logic                 s_tuser;  // req_type
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;  // neighbour[3:0], edge_weight[19:4], zero pad
	logic                 m_tuser;  // error
	logic                 m_tlast;

	int mismatches;
	int pending;
	int results_seen;
	int errors_seen;

	int cycle_count = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int n_queries = 0;
	int n_modifies = 0;
	logic s_accepted = 1'b0;

	weighted_graph_edge_store #(
		.NUM_VERTICES(NV)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	weighted_graph_edge_store_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.mismatches(mismatches),
		.pending(pending),
		.results_seen(results_seen),
		.errors_seen(errors_seen)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count,
				pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// note whether the input transaction went through at this edge
	always @(posedge clk)
		s_accepted <= s_tvalid && s_tready;

	// receiver stall pattern: free-running, random, mostly stalled, periodic
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 80);
		end
		stall_left--;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 4) == 0);
			default: m_tready <= (stall_left % 3 != 0);
		endcase
	end

	// send one request; the sender runs in bursts with idle gaps between them
	task automatic send_request(input logic req_kind, input logic [VERTEX_W-1:0] va,
			input logic [VERTEX_W-1:0] vb, input logic [WEIGHT_W-1:0] w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= req_kind;
		s_tdata  <= {w, vb, va};
		do @(negedge clk); while (!s_accepted);
		if (req_kind == REQ_QUERY)
			n_queries++;
		else
			n_modifies++;
	endtask

	// query with random content in the fields it ignores
	task automatic query_vertex(input logic [VERTEX_W-1:0] va);
		send_request(REQ_QUERY, va, VERTEX_W'($urandom), WEIGHT_W'($urandom));
	endtask

	task automatic modify_edge(input logic [VERTEX_W-1:0] va, input logic [VERTEX_W-1:0] vb,
			input logic [WEIGHT_W-1:0] w);
		send_request(REQ_MODIFY, va, vb, w);
	endtask

	function automatic logic [VERTEX_W-1:0] any_vertex();
		return VERTEX_W'($urandom_range(1, NV));
	endfunction

	// stimulus
	initial begin
		int pick;
		int insert_pct;
		int remove_pct;
		s_tvalid = 1'b0;
		s_tuser  = REQ_QUERY;
		s_tdata  = '0;
		// assert reset just after time zero so every reset-sensitive process sees the edge
		#1 arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// errors on an empty graph and on out-of-range vertices
		query_vertex(4'd1);
		query_vertex(4'd0);
		query_vertex(4'd15);
		modify_edge(4'd0, 4'd1, 16'h0001);
		modify_edge(4'd2, 4'd9, 16'h0001);
		modify_edge(4'd15, 4'd15, 16'hffff);
		modify_edge(4'd1, 4'd2, 16'h0000);

		// inserts at weight extremes, a self-loop, then queries
		modify_edge(4'd1, 4'd2, 16'h8000);
		modify_edge(4'd1, 4'd8, 16'h7fff);
		modify_edge(4'd8, 4'd8, 16'h0001);
		modify_edge(4'd3, 4'd1, 16'hffff);
		query_vertex(4'd1);
		query_vertex(4'd8);

		// overwrite, then remove so vertex 2 is left with no edges
		modify_edge(4'd2, 4'd1, 16'h5555);
		query_vertex(4'd1);
		modify_edge(4'd1, 4'd2, 16'h0000);
		query_vertex(4'd2);

		// vertex 5 with every possible neighbour, itself included
		for (int j = 1; j <= NV; j++)
			modify_edge(4'd5, VERTEX_W'(j), WEIGHT_W'($urandom));
		query_vertex(4'd5);

		// random traffic, alternating dense and sparse phases
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			insert_pct = ((i / 75) % 2 == 0) ? 40 : 15;
			remove_pct = ((i / 75) % 2 == 0) ? 15 : 40;
			pick = $urandom_range(0, 99);
			if (pick < insert_pct)
				modify_edge(any_vertex(), any_vertex(), WEIGHT_W'($urandom));
			else if (pick < insert_pct + remove_pct)
				modify_edge(any_vertex(), any_vertex(), '0);
			else if (pick < 88)
				query_vertex(any_vertex());
			else
				send_request(1'($urandom), VERTEX_W'($urandom), VERTEX_W'($urandom),
					WEIGHT_W'($urandom));
		end
		s_tvalid <= 1'b0;

		// drain
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d queries and %0d modifies over %0d cycles", n_queries,
			n_modifies, cycle_count);
		$display("checked %0d results, %0d of them error results, %0d mismatches",
			results_seen, errors_seen, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
